// ===== hw/rtl/brl_pkg.sv =====
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types and constants for the block index range lookup.
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int KEY_W = 64;
    localparam int OFF_W = 48;
    localparam int CMD_W = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_CHK_CMP,
        ST_OFF_RD,
        ST_OFF_START,
        ST_OFF_END,
        ST_FIN
    } brl_state_t;

    typedef struct packed {
        logic [OFF_W-1:0] block_start;
        logic [OFF_W-1:0] byte_count;
    } brl_res_t;

endpackage

// ===== hw/rtl/brl_ram.sv =====
// ----------------------------------------------------------------------------
// brl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brl_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/brl_search.sv =====
// ----------------------------------------------------------------------------
// brl_search
// Command sequencer: table append/clear, binary search over the key RAM,
// lower-bound fix-up and offset fetch for the selected block.
// ----------------------------------------------------------------------------
module brl_search #(
    parameter int MAX_BLOCKS = 1024,
    parameter int AW         = 10,
    parameter int CW         = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [brl_pkg::CMD_W-1:0]     cmd,
    input  logic [brl_pkg::KEY_W-1:0]     key,
    input  logic [brl_pkg::OFF_W-1:0]     entry_offset,
    input  logic                          follow,
    input  logic [brl_pkg::OFF_W-1:0]     rhs_start,
    output logic                          res_valid,
    output brl_pkg::brl_res_t             res,
    input  logic                          res_take
);

    import brl_pkg::*;

    brl_state_t       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    len_reg, len_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [KEY_W-1:0] k_reg, k_next;
    logic             follow_reg, follow_next;
    logic             zero_reg, zero_next;
    logic [OFF_W-1:0] start_reg, start_next;
    logic [OFF_W-1:0] end_reg, end_next;

    logic             accept;
    logic             has_room;
    logic             mem_we;
    logic [CW-1:0]    half;
    logic [CW-1:0]    mid;
    logic [CW-1:0]    pos_inc;
    logic             has_next;
    logic             miss;
    logic [CW-1:0]    sel;
    logic [CW-1:0]    sel_inc;
    logic [AW-1:0]    key_raddr;
    logic [AW-1:0]    off_raddr;
    logic [KEY_W-1:0] key_rdata;
    logic [OFF_W-1:0] off_rdata;

    assign accept   = in_valid && !in_stall;
    assign has_room = count_reg < CW'(MAX_BLOCKS);
    assign mem_we   = accept && (cmd == CMD_APPEND) && has_room;
    assign half     = len_reg >> 1;
    assign mid      = lo_reg + half;
    assign pos_inc  = pos_reg + CW'(1);
    assign has_next = pos_inc < count_reg;
    assign miss     = (lo_reg == count_reg) || (key_rdata > k_reg);
    assign sel      = miss ? (lo_reg - CW'(1)) : lo_reg;
    assign sel_inc  = sel + CW'(1);

    brl_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (KEY_W),
        .AW    (AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (key),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    brl_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (OFF_W),
        .AW    (AW)
    ) u_off_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (entry_offset),
        .raddr (off_raddr),
        .rdata (off_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (cmd == CMD_QUERY))
                begin
                    state_next = (count_reg == '0) ? ST_FIN : ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:   state_next = (len_reg == '0) ? ST_CHK_CMP : ST_SRCH_CMP;
            ST_SRCH_CMP:  state_next = ST_SRCH_RD;
            ST_CHK_CMP:   state_next = ST_OFF_RD;
            ST_OFF_RD:    state_next = ST_OFF_START;
            ST_OFF_START: state_next = ST_OFF_END;
            ST_OFF_END:   state_next = ST_FIN;
            ST_FIN:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        res_valid = (state_reg == ST_FIN);
        key_raddr = mid[AW-1:0];
        off_raddr = (state_reg == ST_OFF_RD) ? pos_reg[AW-1:0] : pos_inc[AW-1:0];
        res.block_start = start_reg;
        if (zero_reg || (end_reg < start_reg))
        begin
            res.byte_count = '0;
        end
        else
        begin
            res.byte_count = end_reg - start_reg;
        end
    end

    // datapath
    always_comb
    begin
        count_next  = count_reg;
        lo_next     = lo_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        follow_next = follow_reg;
        zero_next   = zero_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (has_room)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_QUERY:
                        begin
                            k_next      = key;
                            follow_next = follow;
                            lo_next     = '0;
                            len_next    = count_reg;
                            zero_next   = (count_reg == '0);
                            start_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SRCH_CMP:
            begin
                if (key_rdata < k_reg)
                begin
                    lo_next  = mid + CW'(1);
                    len_next = len_reg - half - CW'(1);
                end
                else
                begin
                    len_next = half;
                end
            end
            ST_CHK_CMP:
            begin
                if (miss && (lo_reg == '0))
                begin
                    pos_next  = '0;
                    zero_next = 1'b1;
                end
                else if (follow_reg && (sel_inc < count_reg))
                begin
                    pos_next = sel_inc;
                end
                else
                begin
                    pos_next = sel;
                end
            end
            ST_OFF_START:
            begin
                start_next = off_rdata;
            end
            ST_OFF_END:
            begin
                end_next = has_next ? off_rdata : rhs_start;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        len_reg    <= len_next;
        pos_reg    <= pos_next;
        k_reg      <= k_next;
        follow_reg <= follow_next;
        zero_reg   <= zero_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
    end

endmodule

// ===== hw/rtl/block_index_range_lookup_core.sv =====
// ----------------------------------------------------------------------------
// block_index_range_lookup_core
// Sparse block index with lower-bound lookup over a RAM-resident table.
// ----------------------------------------------------------------------------
// One item is handled at a time. A query runs a binary search over the key
// RAM, each halving step being a RAM read state followed by a compare state.
// With n stored entries there are at most ceil(log2(n+1)) steps. The search
// is followed by the lower-bound check and the offset fetch before the result
// reaches the output register. A query on an empty table goes straight to the
// result. The result register lets the next item be accepted while a result
// waits on out_stall.
module block_index_range_lookup_core #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [brl_pkg::OFF_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [brl_pkg::CMD_W-1:0]   cmd,
    input  logic [brl_pkg::KEY_W-1:0]   key,
    input  logic [brl_pkg::OFF_W-1:0]   entry_offset,
    input  logic                        follow,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [brl_pkg::OFF_W-1:0]   block_start,
    output logic [brl_pkg::OFF_W-1:0]   byte_count
);

    import brl_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    logic [OFF_W-1:0] rhs_start_reg;
    logic             out_valid_reg, out_valid_next;
    brl_res_t         out_res_reg;
    logic             res_valid;
    brl_res_t         res;
    logic             res_take;

    brl_search #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (AW),
        .CW         (CW)
    ) u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .key          (key),
        .entry_offset (entry_offset),
        .follow       (follow),
        .rhs_start    (rhs_start_reg),
        .res_valid    (res_valid),
        .res          (res),
        .res_take     (res_take)
    );

    assign res_take       = res_valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = res_take || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rhs_start_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                rhs_start_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign block_start = out_res_reg.block_start;
    assign byte_count  = out_res_reg.byte_count;

endmodule
